// ===== sv/rdr_pkg.sv =====
// Shared types for the restoring divider with rounding.
// Holds the sequencer state encoding and the sequencer-to-datapath control bundle.
// No dependencies.
`timescale 1ns / 1ps

package rdr_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROUND,
        ST_HOLD
    } rdr_state_t;

    // Control strobes from sequencer to datapath and output register
    typedef struct packed {
        logic load;
        logic step;
        logic round;
        logic push;
    } rdr_ctrl_t;

endpackage

// ===== sv/rdr_datapath.sv =====
// Datapath of the restoring divider: operand, remainder and quotient registers
// around one shared subtract-and-compare unit. Depends on rdr_pkg.
`timescale 1ns / 1ps

module rdr_datapath #(
    parameter int DATA_WIDTH = 31
) (
    input  logic                  clk,
    input  rdr_pkg::rdr_ctrl_t    ctrl,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    input  logic                  round_mode,
    output logic [DATA_WIDTH-1:0] res_quotient,
    output logic                  res_dbz
);
    import rdr_pkg::*;

    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] nq_reg, nq_next;
    logic [DATA_WIDTH-1:0] den_reg;
    logic                  rnd_reg;
    logic                  dbz_reg;

    logic                  shift_in;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH+1:0] diff;
    logic                  fits;

    // Shared unit: shift remainder left, subtract divisor, borrow says no fit
    always_comb
    begin
        shift_in = ctrl.round ? 1'b0 : nq_reg[DATA_WIDTH-1];
        trial    = {rem_reg, shift_in};
        diff     = {1'b0, trial} - {2'b00, den_reg};
        fits     = ~diff[DATA_WIDTH+1];
    end

    // Next remainder and quotient for a division step or the rounding step
    always_comb
    begin
        rem_next = rem_reg;
        nq_next  = nq_reg;
        if (ctrl.step)
        begin
            rem_next = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
            nq_next  = {nq_reg[DATA_WIDTH-2:0], fits};
        end
        else if (ctrl.round && rnd_reg && fits)
        begin
            nq_next = nq_reg + {{(DATA_WIDTH-1){1'b0}}, 1'b1};
        end
    end

    // Load operands on accept, then advance one quotient bit per step
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= '0;
            nq_reg  <= dividend;
            den_reg <= divisor;
            rnd_reg <= round_mode;
            dbz_reg <= (divisor == '0);
        end
        else
        begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
        end
    end

    // Saturate on divide by zero
    assign res_quotient = dbz_reg ? '1 : nq_reg;
    assign res_dbz      = dbz_reg;

endmodule

// ===== sv/rdr_seq.sv =====
// Sequencer of the restoring divider: state machine and step counter that
// drive the shared datapath unit. Depends on rdr_pkg.
`timescale 1ns / 1ps

module rdr_seq #(
    parameter int DATA_WIDTH = 31
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               zero_div,
    input  logic               out_busy,
    output logic               in_ready,
    output rdr_pkg::rdr_ctrl_t ctrl
);
    import rdr_pkg::*;

    localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    rdr_state_t     state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and control strobes
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    cnt_next   = CW'(DATA_WIDTH - 1);
                    state_next = zero_div ? ST_HOLD : ST_DIV;
                end
            end
            ST_DIV:
            begin
                ctrl.step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_ROUND;
                else
                    cnt_next = cnt_reg - CW'(1);
            end
            ST_ROUND:
            begin
                ctrl.round = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                // Wait until the output register can take the item
                if (!out_busy)
                begin
                    ctrl.push  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/restoring_divider_round.sv =====
// Top level of the unsigned restoring divider with optional half-up rounding.
// Instantiates rdr_seq and rdr_datapath; uses rdr_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries dividend, divisor and round_mode.
//   Output channel (out_valid/out_ready) carries quotient and divide_by_zero.
//   One result item leaves for every input item, in order.
//   From accept to out_valid, a nonzero divisor passes through one division
//   state per quotient bit, one rounding state and the hold state, which waits
//   for and loads the output register; a zero divisor goes straight to the hold
//   state and gives all ones and divide_by_zero = 1. A new item is not accepted
//   until the sequencer is through with the last: the single subtract-and-compare
//   unit produces one quotient bit per cycle, and in_ready is high only while
//   the sequencer is idle.
//   The output register holds a finished item, so a new item is accepted
//   while the previous result waits; if the receiver still stalls when the
//   next result is done, the sequencer holds it and in_ready stays low.
//   Reset (rst_n low, asynchronous) empties the output register and returns
//   the sequencer to idle; no item is in flight afterwards.
`timescale 1ns / 1ps

module restoring_divider_round #(
    parameter int DATA_WIDTH = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    input  logic                  round_mode,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic                  divide_by_zero
);
    import rdr_pkg::*;

    rdr_ctrl_t              ctrl;
    logic                   out_busy;
    logic [DATA_WIDTH-1:0]  res_quotient;
    logic                   res_dbz;

    logic                   out_valid_reg;
    logic [DATA_WIDTH-1:0]  quotient_reg;
    logic                   dbz_reg;

    // Output register is busy while it holds an item not taken this cycle
    assign out_busy = out_valid_reg && !out_ready;

    rdr_seq #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .zero_div (divisor == '0),
        .out_busy (out_busy),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    rdr_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk          (clk),
        .ctrl         (ctrl),
        .dividend     (dividend),
        .divisor      (divisor),
        .round_mode   (round_mode),
        .res_quotient (res_quotient),
        .res_dbz      (res_dbz)
    );

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.push)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            quotient_reg <= res_quotient;
            dbz_reg      <= res_dbz;
        end
    end

    assign out_valid      = out_valid_reg;
    assign quotient       = quotient_reg;
    assign divide_by_zero = dbz_reg;

endmodule

// ===== sv/rdr_checker.sv =====
// Port-level checks for restoring_divider_round, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module rdr_checker #(
    parameter int DATA_WIDTH = 31
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [DATA_WIDTH-1:0] divisor,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [DATA_WIDTH-1:0] quotient,
    input logic                  divide_by_zero
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quotient)
            && $stable(divide_by_zero))
        else $error("stalled result item changed");

    // Go busy after accepting an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // Saturate on divide by zero
    a_dbz_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> (&quotient))
        else $error("divide by zero did not saturate");

    // A zero divisor accepted while the output is free passes the hold state and then the output register
    a_dbz_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (divisor == '0) && (!out_valid || out_ready)
            |-> ##2 out_valid && divide_by_zero)
        else $error("divide by zero result late");

endmodule

bind restoring_divider_round rdr_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_rdr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .divisor        (divisor),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .quotient       (quotient),
    .divide_by_zero (divide_by_zero)
);

// ===== bench/restoring_divider_round_test.sv =====
// Self-checking testbench for restoring_divider_round (no package types needed).
// Drives random and corner-case divisions through the valid/ready channels and
// checks every result against a bit-accurate long-division predictor.
`timescale 1ns / 1ps

module restoring_divider_round_test;

    localparam int DW         = 31;
    localparam int NUM_RANDOM = 1650;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = DW + 8;

    typedef struct {
        logic [DW-1:0] dividend;
        logic [DW-1:0] divisor;
        logic          round_mode;
    } div_req_t;

    typedef struct {
        logic [DW-1:0] quotient;
        logic          divide_by_zero;
    } div_res_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
    logic          round_mode;
    logic          out_valid;
    logic          out_ready;
    logic [DW-1:0] quotient;
    logic          divide_by_zero;

    div_req_t pending_divs[$];
    div_res_t expected_quotients[$];
    div_req_t next_div;
    div_res_t got_quotient;
    div_res_t want_quotient;
    int       mismatch_count = 0;
    int       tx_wait = 0;
    bit       tx_calm = 0;
    int       rx_wait = 0;
    bit       rx_calm = 0;
    int       idle_cycles = 0;

    restoring_divider_round #(
        .DATA_WIDTH(DW)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .dividend      (dividend),
        .divisor       (divisor),
        .round_mode    (round_mode),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .quotient      (quotient),
        .divide_by_zero(divide_by_zero)
    );

    // Unsigned restoring division, one quotient bit per step, then half-up rounding
    function automatic div_res_t divide_round(logic [DW-1:0] num, logic [DW-1:0] den,
                                              logic rnd);
        div_res_t    res;
        logic [DW:0] rem;
        logic [DW:0] rem2;
        res.quotient       = '0;
        res.divide_by_zero = 1'b0;
        rem                = '0;
        if (den == '0)
        begin
            res.quotient       = '1;
            res.divide_by_zero = 1'b1;
            return res;
        end
        for (int k = DW - 1; k >= 0; k--)
        begin
            rem          = {rem[DW-1:0], num[k]};
            res.quotient = {res.quotient[DW-2:0], 1'b0};
            if (rem >= {1'b0, den})
            begin
                rem             = rem - {1'b0, den};
                res.quotient[0] = 1'b1;
            end
        end
        rem2 = {rem[DW-1:0], 1'b0};
        if (rnd && rem2 >= {1'b0, den})
            res.quotient = res.quotient + DW'(1);
        return res;
    endfunction

    // Random operand with a random bit length, so every alignment gets exercised
    function automatic logic [DW-1:0] rand_operand();
        int          len;
        logic [31:0] mask;
        len  = $urandom_range(0, DW);
        mask = (32'h1 << len) - 1;
        return DW'($urandom & mask);
    endfunction

    task automatic add_div(logic [DW-1:0] num, logic [DW-1:0] den, logic rnd);
        div_req_t req;
        req.dividend   = num;
        req.divisor    = den;
        req.round_mode = rnd;
        pending_divs.push_back(req);
    endtask

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Fill the queue of divisions: corner cases first, then random mix
    initial
    begin
        longint d;
        longint q;
        longint r;
        // zero divisor, both rounding modes
        add_div('0, '0, 1'b0);
        add_div('1, '0, 1'b1);
        add_div(DW'(12345), '0, 1'b0);
        // extremes of the operands
        add_div('0, '1, 1'b1);
        add_div('1, '1, 1'b0);
        add_div('1, '1, 1'b1);
        add_div('1, DW'(1), 1'b0);
        add_div('1, DW'(1), 1'b1);
        add_div(DW'(1), '1, 1'b0);
        add_div(DW'(1), '1, 1'b1);
        add_div('1, DW'(2), 1'b1);
        add_div('1, DW'(3), 1'b1);
        add_div('1, DW'(2), 1'b0);
        // dividend below divisor: rounds up only when twice the dividend reaches it
        add_div(DW'(5), DW'(9), 1'b1);
        add_div(DW'(4), DW'(8), 1'b1);
        add_div(DW'(3), DW'(8), 1'b1);
        add_div(DW'(5), DW'(9), 1'b0);
        add_div(DW'(31'h3FFF_FFFF), '1, 1'b1);
        add_div(DW'(31'h4000_0000), '1, 1'b1);
        // exact half and just below
        add_div(DW'(7), DW'(2), 1'b1);
        add_div(DW'(7), DW'(2), 1'b0);
        add_div(DW'(14), DW'(4), 1'b1);
        add_div(DW'(13), DW'(4), 1'b1);
        add_div(DW'(100), DW'(7), 1'b1);
        add_div('0, DW'(1), 1'b0);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            case ($urandom_range(0, 9))
                0:
                    add_div(DW'($urandom), '0, 1'(($urandom)));
                1, 2:
                    add_div(DW'($urandom), DW'($urandom), 1'(($urandom)));
                3, 4:
                begin
                    // remainder near half of the divisor
                    d = $urandom_range(1, 32'h7FFF);
                    q = $urandom_range(0, 32'hFFFF);
                    r = (d >> 1) + $urandom_range(0, 2) - 1;
                    if (r < 0)
                        r = 0;
                    if (r > d - 1)
                        r = d - 1;
                    add_div(DW'(q * d + r), DW'(d), 1'(($urandom)));
                end
                5:
                    add_div(DW'($urandom), DW'($urandom_range(1, 16)), 1'(($urandom)));
                default:
                    add_div(rand_operand(), rand_operand(), 1'(($urandom)));
            endcase
        end
    end

    // Driver: present queued items, hold each until accepted, idle at random between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            dividend   <= '0;
            divisor    <= '0;
            round_mode <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                expected_quotients.push_back(divide_round(dividend, divisor, round_mode));
                if ($urandom_range(0, 19) == 0)
                    tx_calm = !tx_calm;
                tx_wait = tx_calm ? 0 : $urandom_range(0, 4);
            end
            if (tx_wait > 0)
            begin
                tx_wait--;
                in_valid <= 1'b0;
            end
            else if (pending_divs.size() > 0)
            begin
                next_div = pending_divs.pop_front();
                in_valid   <= 1'b1;
                dividend   <= next_div.dividend;
                divisor    <= next_div.divisor;
                round_mode <= next_div.round_mode;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check each result item, stall the output at random between items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_quotient.quotient       = quotient;
                got_quotient.divide_by_zero = divide_by_zero;
                if (expected_quotients.size() == 0)
                    report_mismatch($sformatf("unexpected result quotient=%h", quotient));
                else
                begin
                    want_quotient = expected_quotients.pop_front();
                    if (got_quotient.quotient !== want_quotient.quotient)
                        report_mismatch($sformatf("quotient %h, expected %h",
                            got_quotient.quotient, want_quotient.quotient));
                    if (got_quotient.divide_by_zero !== want_quotient.divide_by_zero)
                        report_mismatch($sformatf("divide_by_zero %b, expected %b",
                            got_quotient.divide_by_zero, want_quotient.divide_by_zero));
                end
                if ($urandom_range(0, 19) == 0)
                    rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 4);
            end
            else if (rx_wait > 0)
                rx_wait--;
            out_ready <= (rx_wait == 0);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Drain: wait until every item is accepted and answered, then report
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        while (pending_divs.size() != 0 || in_valid || expected_quotients.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== restoring_divider_round.f =====
sv/rdr_pkg.sv
sv/rdr_datapath.sv
sv/rdr_seq.sv
sv/restoring_divider_round.sv
sv/rdr_checker.sv
bench/restoring_divider_round_test.sv
